### hw/rtl/sdeq_pkg.sv
// ----------------------------------------------------------------------------
// sdeq_pkg
// Shared types, codes and defaults for the sorted double-ended queue.
// ----------------------------------------------------------------------------
package sdeq_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int KEY_BITS_DEF = 32;
  localparam int ID_BITS_DEF  = 8;

  // command codes
  localparam logic [1:0] CMD_INSERT  = 2'd0;
  localparam logic [1:0] CMD_POP_MIN = 2'd1;
  localparam logic [1:0] CMD_POP_MAX = 2'd2;
  localparam logic [1:0] CMD_QUERY   = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] exec_time;
    logic [7:0]  process_id;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  out_process_id;
    logic [31:0] out_exec_time;
    logic        is_empty;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic latch;    // capture the accepted transaction
    logic decode;   // resolve trivial cases, issue first read
    logic walk;     // one step of the insertion walk
    logic pop;      // capture popped entry
    logic respond;  // move result into output register
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_walk;
    logic need_pop;
    logic walk_done;
    logic out_free;
  } dp_sts_t;

endpackage

### hw/rtl/sdeq_ram.sv
// ----------------------------------------------------------------------------
// sdeq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sdeq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### hw/rtl/sdeq_ctrl.sv
// ----------------------------------------------------------------------------
// sdeq_ctrl
// Sequencer: accept, decode, insertion walk or pop read, respond.
// ----------------------------------------------------------------------------
module sdeq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sdeq_pkg::dp_sts_t sts,
  output sdeq_pkg::ctl_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_WALK,
    S_POP,
    S_RESP
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r;

  assign in_ready = in_ready_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        if (sts.need_walk) begin
          state_nxt = S_WALK;
        end else if (sts.need_pop) begin
          state_nxt = S_POP;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (sts.walk_done) begin
          state_nxt = S_RESP;
        end
      end
      S_POP: begin
        cmd.pop   = 1'b1;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.respond = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == S_IDLE);
    end
  end

endmodule

### hw/rtl/sdeq_dp.sv
// ----------------------------------------------------------------------------
// sdeq_dp
// Datapath: ring pointers, entry count, insertion walk, result registers.
// ----------------------------------------------------------------------------
module sdeq_dp #(
  parameter int CAPACITY = sdeq_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = sdeq_pkg::KEY_BITS_DEF,
  parameter int ID_BITS  = sdeq_pkg::ID_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  sdeq_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sdeq_pkg::out_item_t out_data,
  input  sdeq_pkg::ctl_cmd_t  cmd,
  output sdeq_pkg::dp_sts_t   sts
);

  localparam int PW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int DW = KEY_BITS + ID_BITS;
  localparam logic [PW-1:0] LAST = PW'(CAPACITY - 1);

  logic [1:0]          item_cmd_r;
  logic [KEY_BITS-1:0] key_r;
  logic [ID_BITS-1:0]  id_r;

  logic [CW-1:0] count_r, count_nxt;
  logic [PW-1:0] head_r, head_nxt;
  logic [PW-1:0] tail_r, tail_nxt;
  logic [PW-1:0] w_r, w_nxt;
  logic [CW-1:0] rem_r, rem_nxt;

  sdeq_pkg::out_item_t res_r, res_nxt;
  sdeq_pkg::out_item_t out_r;
  logic                out_valid_r;

  logic [PW-1:0] rd_addr, wr_addr;
  logic [DW-1:0] rd_data, wr_data;
  logic          wr_en;

  logic [KEY_BITS-1:0] rd_key;
  logic [ID_BITS-1:0]  rd_id;
  logic [63:0]         key_in_ext, key_out_ext;
  logic [31:0]         id_in_ext, id_out_ext;

  logic [PW-1:0] tail_prev, w_prev, w_prev2, head_next, tail_next;
  logic          full, empty, place;

  function automatic logic [PW-1:0] ring_prev(input logic [PW-1:0] p);
    ring_prev = (p == '0) ? LAST : p - PW'(1);
  endfunction

  function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
    ring_next = (p == LAST) ? '0 : p + PW'(1);
  endfunction

  sdeq_ram #(
    .WIDTH (DW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // field width adaptation
  assign key_in_ext  = 64'(in_data.exec_time);
  assign id_in_ext   = 32'(in_data.process_id);
  assign rd_key      = rd_data[KEY_BITS-1:0];
  assign rd_id       = rd_data[DW-1:KEY_BITS];
  assign key_out_ext = 64'(rd_key);
  assign id_out_ext  = 32'(rd_id);

  assign tail_prev = ring_prev(tail_r);
  assign w_prev    = ring_prev(w_r);
  assign w_prev2   = ring_prev(w_prev);
  assign head_next = ring_next(head_r);
  assign tail_next = ring_next(tail_r);

  assign full  = (count_r == CW'(CAPACITY));
  assign empty = (count_r == '0);
  // stop when nothing left below, or the entry below is not bigger
  assign place = (rem_r == '0) || (rd_key <= key_r);

  assign sts.need_walk = (item_cmd_r == sdeq_pkg::CMD_INSERT) && !full;
  assign sts.need_pop  = ((item_cmd_r == sdeq_pkg::CMD_POP_MIN) ||
                          (item_cmd_r == sdeq_pkg::CMD_POP_MAX)) && !empty;
  assign sts.walk_done = place;
  assign sts.out_free  = !out_valid_r || out_ready;

  always_comb begin
    count_nxt = count_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    w_nxt     = w_r;
    rem_nxt   = rem_r;
    res_nxt   = res_r;
    rd_addr   = tail_prev;
    wr_en     = 1'b0;
    wr_addr   = w_r;
    wr_data   = {id_r, key_r};

    res_nxt.out_process_id = '0;
    res_nxt.out_exec_time  = '0;

    if (cmd.decode) begin
      res_nxt.status   = sdeq_pkg::ST_OK;
      res_nxt.is_empty = empty;
      case (item_cmd_r)
        sdeq_pkg::CMD_INSERT: begin
          if (full) begin
            res_nxt.status = sdeq_pkg::ST_FULL;
          end
          w_nxt   = tail_r;
          rem_nxt = count_r;
          rd_addr = tail_prev;
        end
        sdeq_pkg::CMD_POP_MIN: begin
          if (empty) begin
            res_nxt.status = sdeq_pkg::ST_EMPTY;
          end
          rd_addr = head_r;
        end
        sdeq_pkg::CMD_POP_MAX: begin
          if (empty) begin
            res_nxt.status = sdeq_pkg::ST_EMPTY;
          end
          rd_addr = tail_prev;
        end
        default: begin
          res_nxt.status = sdeq_pkg::ST_OK;
        end
      endcase
    end

    if (cmd.walk) begin
      wr_en = 1'b1;
      if (place) begin
        wr_data          = {id_r, key_r};
        count_nxt        = count_r + CW'(1);
        tail_nxt         = tail_next;
        res_nxt.status   = sdeq_pkg::ST_OK;
        res_nxt.is_empty = 1'b0;
      end else begin
        // move the bigger entry up one slot, fetch the next one down
        wr_data = rd_data;
        w_nxt   = w_prev;
        rem_nxt = rem_r - CW'(1);
        rd_addr = w_prev2;
      end
    end

    if (cmd.pop) begin
      res_nxt.status         = sdeq_pkg::ST_OK;
      res_nxt.out_process_id = id_out_ext[7:0];
      res_nxt.out_exec_time  = key_out_ext[31:0];
      res_nxt.is_empty       = (count_r == CW'(1));
      count_nxt              = count_r - CW'(1);
      if (item_cmd_r == sdeq_pkg::CMD_POP_MIN) begin
        head_nxt = head_next;
      end else begin
        tail_nxt = tail_prev;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_cmd_r <= in_data.command;
      key_r      <= key_in_ext[KEY_BITS-1:0];
      id_r       <= id_in_ext[ID_BITS-1:0];
    end
    if (cmd.decode || cmd.walk || cmd.pop) begin
      res_r <= res_nxt;
    end
    if (cmd.respond) begin
      out_r <= res_r;
    end
    w_r   <= w_nxt;
    rem_r <= rem_nxt;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      if (cmd.respond) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### hw/rtl/sorted_double_ended_queue.sv
// ----------------------------------------------------------------------------
// sorted_double_ended_queue
// Double-ended priority queue kept as a sorted ring in RAM.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : valid/ready channel carrying one command per transaction
//           (insert, pop smallest, pop biggest, query empty).
//   out_* : valid/ready channel, exactly one result transaction per command.
//   Entries live in a ring buffer in one RAM, ascending from head to tail.
//   Pop smallest advances head, pop biggest retreats tail; a pop goes
//   through decode, pop read and respond states before out_valid rises.
//   Query and rejected commands skip the pop read. Insert walks down from
//   the tail one entry per cycle, moving each bigger key up one slot until
//   a key <= the new one is found. The single RAM read/write port pair sets
//   this one-entry-per-cycle walk. Equal keys keep arrival order.
//   One command is in flight at a time; in_ready rises again once the result
//   sits in the output register, so the next command can be taken while
//   the previous result may still wait for out_ready.
//   Reset (rst_n low, synchronous) empties the queue at once; in_ready is
//   low during reset and rises in the cycle after it. RAM contents are not
//   cleared, and an entry's read data is never used before it is written.
//   A stalled receiver holds the result in the output register; the next
//   result waits in the datapath until the register frees up.
// ----------------------------------------------------------------------------
module sorted_double_ended_queue #(
  parameter int CAPACITY = sdeq_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = sdeq_pkg::KEY_BITS_DEF,
  parameter int ID_BITS  = sdeq_pkg::ID_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sdeq_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sdeq_pkg::out_item_t out_data
);

  // command/status bundles between sequencer and datapath
  sdeq_pkg::ctl_cmd_t cmd;
  sdeq_pkg::dp_sts_t  sts;

  sdeq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sdeq_dp #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS),
    .ID_BITS  (ID_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

### dv/tb_sorted_double_ended_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_double_ended_queue
// Self-checking bench for the sorted double-ended queue. Commands go in on a
// valid/ready channel with random gaps. A scoreboard that keeps its own sorted
// list predicts each result, and every returned transaction is checked field
// by field against it.
// ----------------------------------------------------------------------------
module tb_sorted_double_ended_queue;
  import sdeq_pkg::*;

  localparam int QUEUE_DEPTH = CAPACITY_DEF;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  // commands waiting to be driven, and results still owed by the block
  in_item_t    pending_cmds[$];
  out_item_t   owed_results[$];

  // scoreboard copy of the queue contents, ascending by key
  logic [31:0] sorted_keys[QUEUE_DEPTH];
  logic [7:0]  sorted_ids[QUEUE_DEPTH];
  int          held_count  = 0;

  int unsigned sent_count  = 0;
  int unsigned total_items = 1;
  int unsigned error_count = 0;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  logic        hold_off    = 1'b0;

  sorted_double_ended_queue uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Idle profile by thirds of the run: sender light / receiver heavy, then
  // swapped, then both sides back to back.
  always_comb begin
    case ((sent_count * 3) / total_items)
      0: begin
        send_idle_pct = 9;
        recv_idle_pct = 78;
      end
      1: begin
        send_idle_pct = 78;
        recv_idle_pct = 9;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  end

  // Scoreboard update for one accepted command. Inserts walk down from the
  // tail, shifting bigger keys up, so a new key lands after all equal keys.
  function automatic out_item_t apply_queue_cmd(in_item_t txn);
    out_item_t res;
    int        slot;
    res = '0;
    case (txn.command)
      CMD_INSERT: begin
        if (held_count >= QUEUE_DEPTH) begin
          res.status = ST_FULL;
        end else begin
          slot = held_count;
          while (slot > 0 && sorted_keys[slot-1] > txn.exec_time) begin
            sorted_keys[slot] = sorted_keys[slot-1];
            sorted_ids[slot]  = sorted_ids[slot-1];
            slot--;
          end
          sorted_keys[slot] = txn.exec_time;
          sorted_ids[slot]  = txn.process_id;
          held_count++;
        end
      end
      CMD_POP_MIN: begin
        if (held_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          res.out_exec_time  = sorted_keys[0];
          res.out_process_id = sorted_ids[0];
          for (int i = 1; i < held_count; i++) begin
            sorted_keys[i-1] = sorted_keys[i];
            sorted_ids[i-1]  = sorted_ids[i];
          end
          held_count--;
        end
      end
      CMD_POP_MAX: begin
        if (held_count == 0) begin
          res.status = ST_EMPTY;
        end else begin
          held_count--;
          res.out_exec_time  = sorted_keys[held_count];
          res.out_process_id = sorted_ids[held_count];
        end
      end
      default: ;  // query: only is_empty carries information
    endcase
    res.is_empty = (held_count == 0);
    return res;
  endfunction

  // Driver: on acceptance, log the prediction and load the next command.
  // A transaction that is not yet accepted is held with its payload intact.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        owed_results.push_back(apply_queue_cmd(in_data));
        sent_count <= sent_count + 1;
      end
      if (!in_valid || in_ready) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= pending_cmds.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each returned transaction with the oldest prediction,
  // then pick the next cycle's ready (forced low during the hold-off).
  always @(posedge clk) begin : result_monitor
    out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (owed_results.size() == 0) begin
          $error("unexpected result transaction: %p", out_data);
          error_count++;
        end else begin
          want = owed_results.pop_front();
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            error_count++;
          end
          if (out_data.out_process_id !== want.out_process_id) begin
            $error("out_process_id: expected 0x%02h, got 0x%02h",
                   want.out_process_id, out_data.out_process_id);
            error_count++;
          end
          if (out_data.out_exec_time !== want.out_exec_time) begin
            $error("out_exec_time: expected 0x%08h, got 0x%08h",
                   want.out_exec_time, out_data.out_exec_time);
            error_count++;
          end
          if (out_data.is_empty !== want.is_empty) begin
            $error("is_empty: expected %0d, got %0d", want.is_empty, out_data.is_empty);
            error_count++;
          end
        end
      end
      out_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Back-pressure: receiver goes dark for a long stretch while commands keep
  // coming, so the output register and the datapath fill and in_ready drops.
  initial begin
    wait (sent_count >= 60);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Hard stop in case the handshake locks up.
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic queue_cmd(logic [1:0] cmd, logic [31:0] key, logic [7:0] id);
    in_item_t txn;
    txn.command    = cmd;
    txn.exec_time  = key;
    txn.process_id = id;
    pending_cmds.push_back(txn);
  endtask

  // keys skewed toward a narrow range so ties are common
  function automatic logic [31:0] pick_key();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return 32'($urandom_range(15));
      default: return $urandom;
    endcase
  endfunction

  initial begin : stimulus
    int          style;
    int          roll;
    logic [1:0]  cmd;

    // directed: empty-queue cases, key extremes, ties, both pop ends
    queue_cmd(CMD_QUERY,   $urandom, 8'($urandom));
    queue_cmd(CMD_POP_MIN, $urandom, 8'($urandom));
    queue_cmd(CMD_POP_MAX, $urandom, 8'($urandom));
    queue_cmd(CMD_INSERT,  32'hFFFF_FFFF, 8'hFF);
    queue_cmd(CMD_INSERT,  32'h0000_0000, 8'h00);
    queue_cmd(CMD_INSERT,  32'd5, 8'd1);
    queue_cmd(CMD_INSERT,  32'd5, 8'd2);
    queue_cmd(CMD_INSERT,  32'd5, 8'd3);
    queue_cmd(CMD_QUERY,   $urandom, 8'($urandom));
    queue_cmd(CMD_POP_MIN, $urandom, 8'($urandom));  // key 0
    queue_cmd(CMD_POP_MIN, $urandom, 8'($urandom));  // first of the tied fives
    queue_cmd(CMD_POP_MAX, $urandom, 8'($urandom));  // all-ones key
    queue_cmd(CMD_POP_MAX, $urandom, 8'($urandom));  // last tied five
    queue_cmd(CMD_POP_MIN, $urandom, 8'($urandom));  // drains the queue
    queue_cmd(CMD_POP_MAX, $urandom, 8'($urandom));
    queue_cmd(CMD_QUERY,   $urandom, 8'($urandom));
    queue_cmd(CMD_INSERT,  32'hAAAA_AAAA, 8'h55);
    queue_cmd(CMD_INSERT,  32'h5555_5555, 8'hAA);
    queue_cmd(CMD_INSERT,  32'h0000_0000, 8'h80);
    queue_cmd(CMD_POP_MAX, $urandom, 8'($urandom));
    queue_cmd(CMD_POP_MIN, $urandom, 8'($urandom));
    queue_cmd(CMD_POP_MIN, $urandom, 8'($urandom));
    queue_cmd(CMD_QUERY,   $urandom, 8'($urandom));

    // run the queue past full, then drain it past empty
    repeat (70) queue_cmd(CMD_INSERT, pick_key(), 8'($urandom));
    repeat (70) queue_cmd($urandom_range(1) ? CMD_POP_MIN : CMD_POP_MAX,
                          $urandom, 8'($urandom));

    // random bursts: fill-heavy, drain-heavy or evenly mixed
    while (pending_cmds.size() < 1010) begin
      style = $urandom_range(2);
      repeat ($urandom_range(10, 80)) begin
        roll = $urandom_range(99);
        cmd  = 2'($urandom_range(3));
        if (style == 0 && roll < 85)
          cmd = CMD_INSERT;
        else if (style == 1 && roll < 85)
          cmd = roll[0] ? CMD_POP_MIN : CMD_POP_MAX;
        queue_cmd(cmd, pick_key(), 8'($urandom));
      end
    end
    total_items = pending_cmds.size();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (sent_count != total_items) @(posedge clk);
    while (owed_results.size() != 0) @(posedge clk);
    // slowest command is a full insert walk down through every held entry
    repeat (QUEUE_DEPTH + 40) @(posedge clk);

    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### sorted_double_ended_queue.f
hw/rtl/sdeq_pkg.sv
hw/rtl/sdeq_ram.sv
hw/rtl/sdeq_ctrl.sv
hw/rtl/sdeq_dp.sv
hw/rtl/sorted_double_ended_queue.sv
dv/tb_sorted_double_ended_queue.sv
